FILE: sv/tks_pkg.sv
package tks_pkg;

   localparam int VERTEX_W = 5;
   localparam int STATUS_W = 3;
   localparam int CFG_W = 6;

   localparam int MAX_VERTICES_DEFAULT = 32;
   localparam int MAX_EDGES_DEFAULT = 256;
   localparam logic [CFG_W-1:0] NUM_VERTICES_RESET = 6'd32;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ACCEPT = 3'd0,
      STATUS_RANGE  = 3'd1,
      STATUS_FULL   = 3'd2,
      STATUS_ORDER  = 3'd3,
      STATUS_CYCLE  = 3'd4
   } status_type;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_SORT = 1'b1
   } opcode_type;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_CLEAR    = 12'b0000_0000_0010,
      ST_CNT_RD   = 12'b0000_0000_0100,
      ST_CNT_WR   = 12'b0000_0000_1000,
      ST_SEED_RD  = 12'b0000_0001_0000,
      ST_SEED_CHK = 12'b0000_0010_0000,
      ST_POP_RD   = 12'b0000_0100_0000,
      ST_POP_GET  = 12'b0000_1000_0000,
      ST_SCAN_RD  = 12'b0001_0000_0000,
      ST_SCAN_WR  = 12'b0010_0000_0000,
      ST_EMIT_RD  = 12'b0100_0000_0000,
      ST_EMIT_OUT = 12'b1000_0000_0000
   } state_type;

endpackage

FILE: sv/tks_ram.sv
module tks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/kahn_topological_sort.sv
// Kahn topological sort over a stored edge list.
// Request: pulse start with req_opcode, req_src_vertex, req_dst_vertex; the
// transaction is taken when start is high and busy is low.
// Add (opcode 0): busy stays low; the status result appears on
// rsp_* in the next cycle with rsp_last set. Adds may follow every cycle.
// Sort (opcode 1): busy rises for the whole run. The time is set by the
// edge memory reads and the in-degree read-modify-writes per edge, all
// through a single in-degree memory. Results are strobed by rsp_valid, one
// cycle each, either the full order (rsp_last on the final vertex) or a
// single STATUS_CYCLE result; a sort with a vertex count of zero gives no
// result and busy stays low. The receiver cannot stall; results are never
// held. csr_wr_en/csr_wr_data write the vertex count; the user writes it
// only while busy is low, as the block itself does not enforce this.
// Reset (synchronous) empties the edge store and sets the vertex count to 32;
// the memories themselves are not cleared.
module kahn_topological_sort #(
   parameter int MAX_VERTICES = tks_pkg::MAX_VERTICES_DEFAULT,
   parameter int MAX_EDGES = tks_pkg::MAX_EDGES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [tks_pkg::VERTEX_W-1:0]  req_src_vertex,
   input  logic [tks_pkg::VERTEX_W-1:0]  req_dst_vertex,
   output logic                          rsp_valid,
   output logic [tks_pkg::STATUS_W-1:0]  rsp_status,
   output logic [tks_pkg::VERTEX_W-1:0]  rsp_vertex,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [tks_pkg::CFG_W-1:0]     csr_wr_data
);

   localparam int VW = tks_pkg::VERTEX_W;
   localparam int EDGE_W = 2 * VW;
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int VAW = $clog2(MAX_VERTICES);
   localparam int VCW = $clog2(MAX_VERTICES + 1);
   localparam int DW = ECW;

   tks_pkg::state_type state_ff, state_in;
   logic [tks_pkg::CFG_W-1:0] num_vertices_ff, num_vertices_in;
   logic [ECW-1:0] edge_count_ff, edge_count_in;
   logic [ECW-1:0] eidx_ff, eidx_in;
   logic [VCW-1:0] idx_ff, idx_in;
   logic [VCW-1:0] head_ff, head_in;
   logic [VCW-1:0] tail_ff, tail_in;
   logic [VW-1:0] u_ff, u_in;
   logic rsp_valid_ff, rsp_valid_in;
   tks_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [VW-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic rsp_last_ff, rsp_last_in;

   logic [VCW-1:0] nv;

   logic edge_wr_en;
   logic [EDGE_W-1:0] edge_rd_data;
   logic [VW-1:0] e_from, e_to;
   logic e_in_range;

   logic deg_wr_en;
   logic [VAW-1:0] deg_wr_addr, deg_rd_addr;
   logic [DW-1:0] deg_wr_data, deg_rd_data;

   logic q_wr_en;
   logic [VW-1:0] q_wr_data, q_rd_data;
   logic [VAW-1:0] q_rd_addr;

   assign nv = (int'(num_vertices_ff) > MAX_VERTICES) ? VCW'(MAX_VERTICES)
                                                      : VCW'(num_vertices_ff);

   assign e_from = edge_rd_data[EDGE_W-1:VW];
   assign e_to = edge_rd_data[VW-1:0];
   assign e_in_range = (int'(e_from) < int'(nv)) && (int'(e_to) < int'(nv));

   tks_ram #(
      .WIDTH (EDGE_W),
      .DEPTH (MAX_EDGES),
      .ADDR_W(EAW)
   ) u_edge_ram (
      .clock  (clock),
      .wr_en  (edge_wr_en),
      .wr_addr(edge_count_ff[EAW-1:0]),
      .wr_data({req_src_vertex, req_dst_vertex}),
      .rd_addr(eidx_in[EAW-1:0]),
      .rd_data(edge_rd_data)
   );

   tks_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_VERTICES),
      .ADDR_W(VAW)
   ) u_deg_ram (
      .clock  (clock),
      .wr_en  (deg_wr_en),
      .wr_addr(deg_wr_addr),
      .wr_data(deg_wr_data),
      .rd_addr(deg_rd_addr),
      .rd_data(deg_rd_data)
   );

   // ready queue; since pops are in order it also holds the visit order
   tks_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_VERTICES),
      .ADDR_W(VAW)
   ) u_queue_ram (
      .clock  (clock),
      .wr_en  (q_wr_en),
      .wr_addr(tail_ff[VAW-1:0]),
      .wr_data(q_wr_data),
      .rd_addr(q_rd_addr),
      .rd_data(q_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      num_vertices_in = csr_wr_en ? csr_wr_data : num_vertices_ff;
      edge_count_in = edge_count_ff;
      eidx_in = eidx_ff;
      idx_in = idx_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      u_in = u_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = tks_pkg::STATUS_ACCEPT;
      rsp_vertex_in = '0;
      rsp_last_in = 1'b0;
      edge_wr_en = 1'b0;
      deg_wr_en = 1'b0;
      deg_wr_addr = '0;
      deg_wr_data = '0;
      deg_rd_addr = '0;
      q_wr_en = 1'b0;
      q_wr_data = '0;
      q_rd_addr = '0;

      unique case (state_ff)
         tks_pkg::ST_IDLE: begin
            if (start) begin
               if (req_opcode == tks_pkg::OP_SORT) begin
                  idx_in = '0;
                  eidx_in = '0;
                  head_in = '0;
                  tail_in = '0;
                  if (nv != '0) begin
                     state_in = tks_pkg::ST_CLEAR;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in = 1'b1;
                  if ((int'(req_src_vertex) >= int'(nv)) ||
                      (int'(req_dst_vertex) >= int'(nv))) begin
                     rsp_status_in = tks_pkg::STATUS_RANGE;
                  end else if (edge_count_ff == ECW'(MAX_EDGES)) begin
                     rsp_status_in = tks_pkg::STATUS_FULL;
                  end else begin
                     rsp_status_in = tks_pkg::STATUS_ACCEPT;
                     edge_wr_en = 1'b1;
                     edge_count_in = edge_count_ff + 1'b1;
                  end
               end
            end
         end
         tks_pkg::ST_CLEAR: begin
            deg_wr_en = 1'b1;
            deg_wr_addr = idx_ff[VAW-1:0];
            if (int'(idx_ff) + 1 == int'(nv)) begin
               idx_in = '0;
               state_in = tks_pkg::ST_CNT_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         tks_pkg::ST_CNT_RD: begin
            if (eidx_ff == edge_count_ff) begin
               state_in = tks_pkg::ST_SEED_RD;
            end else if (e_in_range) begin
               deg_rd_addr = VAW'(e_to);
               state_in = tks_pkg::ST_CNT_WR;
            end else begin
               eidx_in = eidx_ff + 1'b1;
            end
         end
         tks_pkg::ST_CNT_WR: begin
            deg_wr_en = 1'b1;
            deg_wr_addr = VAW'(e_to);
            deg_wr_data = deg_rd_data + 1'b1;
            eidx_in = eidx_ff + 1'b1;
            state_in = tks_pkg::ST_CNT_RD;
         end
         tks_pkg::ST_SEED_RD: begin
            deg_rd_addr = idx_ff[VAW-1:0];
            state_in = tks_pkg::ST_SEED_CHK;
         end
         tks_pkg::ST_SEED_CHK: begin
            if (deg_rd_data == '0) begin
               q_wr_en = 1'b1;
               q_wr_data = VW'(idx_ff);
               tail_in = tail_ff + 1'b1;
            end
            if (int'(idx_ff) + 1 == int'(nv)) begin
               state_in = tks_pkg::ST_POP_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = tks_pkg::ST_SEED_RD;
            end
         end
         tks_pkg::ST_POP_RD: begin
            q_rd_addr = head_ff[VAW-1:0];
            if (head_ff != tail_ff) begin
               state_in = tks_pkg::ST_POP_GET;
            end else if (head_ff == nv) begin
               idx_in = '0;
               state_in = tks_pkg::ST_EMIT_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_status_in = tks_pkg::STATUS_CYCLE;
               rsp_last_in = 1'b1;
               state_in = tks_pkg::ST_IDLE;
            end
         end
         tks_pkg::ST_POP_GET: begin
            u_in = q_rd_data;
            head_in = head_ff + 1'b1;
            eidx_in = '0;
            state_in = tks_pkg::ST_SCAN_RD;
         end
         tks_pkg::ST_SCAN_RD: begin
            if (eidx_ff == edge_count_ff) begin
               state_in = tks_pkg::ST_POP_RD;
            end else if ((e_from == u_ff) && (int'(e_to) < int'(nv))) begin
               deg_rd_addr = VAW'(e_to);
               state_in = tks_pkg::ST_SCAN_WR;
            end else begin
               eidx_in = eidx_ff + 1'b1;
            end
         end
         tks_pkg::ST_SCAN_WR: begin
            // drop the in-degree; enqueue the target when it reaches zero
            if (deg_rd_data != '0) begin
               deg_wr_en = 1'b1;
               deg_wr_addr = VAW'(e_to);
               deg_wr_data = deg_rd_data - 1'b1;
               if (deg_rd_data == DW'(1)) begin
                  q_wr_en = 1'b1;
                  q_wr_data = e_to;
                  tail_in = tail_ff + 1'b1;
               end
            end
            eidx_in = eidx_ff + 1'b1;
            state_in = tks_pkg::ST_SCAN_RD;
         end
         tks_pkg::ST_EMIT_RD: begin
            q_rd_addr = idx_ff[VAW-1:0];
            state_in = tks_pkg::ST_EMIT_OUT;
         end
         tks_pkg::ST_EMIT_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_status_in = tks_pkg::STATUS_ORDER;
            rsp_vertex_in = q_rd_data;
            if (int'(idx_ff) + 1 == int'(nv)) begin
               rsp_last_in = 1'b1;
               state_in = tks_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = tks_pkg::ST_EMIT_RD;
            end
         end
         default: begin
            state_in = tks_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tks_pkg::ST_IDLE;
         num_vertices_ff <= tks_pkg::NUM_VERTICES_RESET;
         edge_count_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         num_vertices_ff <= num_vertices_in;
         edge_count_ff <= edge_count_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eidx_ff <= eidx_in;
      idx_ff <= idx_in;
      u_ff <= u_in;
      rsp_status_ff <= rsp_status_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy = (state_ff != tks_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_last = rsp_last_ff;

   a_cycle_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == tks_pkg::STATUS_CYCLE)) |-> rsp_last)
      else $error("cycle result without last");

   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("queue head passed tail");

   a_tail_le_nv: assert property (@(posedge clock) disable iff (reset)
      busy |-> (int'(tail_ff) <= int'(nv)))
      else $error("more vertices enqueued than exist");

   a_edge_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(edge_count_ff) <= MAX_EDGES)
      else $error("edge count beyond store depth");

endmodule

FILE: tb/sv/kahn_topological_sort_checker.sv
`timescale 1ns / 1ps
module kahn_topological_sort_checker #(
   parameter int MAX_VERTICES = tks_pkg::MAX_VERTICES_DEFAULT,
   parameter int MAX_EDGES = tks_pkg::MAX_EDGES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_opcode,
   input  logic [tks_pkg::VERTEX_W-1:0]  req_src_vertex,
   input  logic [tks_pkg::VERTEX_W-1:0]  req_dst_vertex,
   input  logic                          rsp_valid,
   input  logic [tks_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [tks_pkg::VERTEX_W-1:0]  rsp_vertex,
   input  logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [tks_pkg::CFG_W-1:0]     csr_wr_data,
   output int                            failures,
   output int                            outstanding
);

   typedef struct packed {
      tks_pkg::status_type              status;
      logic [tks_pkg::VERTEX_W-1:0]     vertex;
      logic                             last;
   } sort_result_type;

   logic [tks_pkg::CFG_W-1:0]    vertex_count;
   logic [tks_pkg::VERTEX_W-1:0] edge_src [MAX_EDGES];
   logic [tks_pkg::VERTEX_W-1:0] edge_dst [MAX_EDGES];
   int                           stored_edges;
   sort_result_type              pending_results [$];
   int                           mismatch_count = 0;
   int                           pending_count = 0;

   assign failures = mismatch_count;
   assign outstanding = pending_count;

   // counts above the vertex capacity act as the capacity
   function automatic int active_vertices();
      return (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
   endfunction

   task automatic push_result(tks_pkg::status_type st, logic [tks_pkg::VERTEX_W-1:0] v,
                              logic lst);
      sort_result_type res;
      res.status = st;
      res.vertex = v;
      res.last = lst;
      pending_results = {pending_results, res};
   endtask

   task automatic predict_sort_order();
      int                           nv;
      int                           head;
      int                           tail;
      int                           visited;
      int                           indeg [MAX_VERTICES];
      logic [tks_pkg::VERTEX_W-1:0] ready [MAX_VERTICES];
      logic [tks_pkg::VERTEX_W-1:0] order [MAX_VERTICES];
      logic [tks_pkg::VERTEX_W-1:0] u;
      logic [tks_pkg::VERTEX_W-1:0] t;
      nv = active_vertices();
      for (int i = 0; i < MAX_VERTICES; i++) indeg[i] = 0;
      // stale edges (an endpoint beyond the vertex count) take no part
      for (int e = 0; e < stored_edges; e++)
         if (edge_src[e] < nv && edge_dst[e] < nv) indeg[edge_dst[e]]++;
      head = 0;
      tail = 0;
      visited = 0;
      for (int i = 0; i < nv; i++) begin
         if (indeg[i] == 0) begin
            ready[tail] = tks_pkg::VERTEX_W'(i);
            tail++;
         end
      end
      while (head < tail) begin
         u = ready[head];
         head++;
         order[visited] = u;
         visited++;
         // scan edges in insertion order so release order matches the block
         for (int e = 0; e < stored_edges; e++) begin
            t = edge_dst[e];
            if (edge_src[e] == u && t < nv && indeg[t] > 0) begin
               indeg[t]--;
               if (indeg[t] == 0) begin
                  ready[tail] = t;
                  tail++;
               end
            end
         end
      end
      if (visited != nv) begin
         push_result(tks_pkg::STATUS_CYCLE, '0, 1'b1);
      end else begin
         for (int i = 0; i < nv; i++)
            push_result(tks_pkg::STATUS_ORDER, order[i], i == nv - 1);
      end
   endtask

   always @(posedge clock) begin
      sort_result_type exp_res;
      int              nv;
      if (reset) begin
         vertex_count = tks_pkg::NUM_VERTICES_RESET;
         stored_edges = 0;
         pending_results.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, status %0d vertex %0d last %0b", $time,
                        rsp_status, rsp_vertex, rsp_last);
               mismatch_count++;
            end else begin
               exp_res = pending_results.pop_front();
               if (rsp_status !== exp_res.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d", $time,
                           exp_res.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_vertex !== exp_res.vertex) begin
                  $display("%0t: vertex mismatch, expected %0d, got %0d", $time,
                           exp_res.vertex, rsp_vertex);
                  mismatch_count++;
               end
               if (rsp_last !== exp_res.last) begin
                  $display("%0t: last mismatch, expected %0b, got %0b", $time,
                           exp_res.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            nv = active_vertices();
            if (req_opcode == tks_pkg::OP_SORT) begin
               predict_sort_order();
            end else if (req_src_vertex >= nv || req_dst_vertex >= nv) begin
               push_result(tks_pkg::STATUS_RANGE, '0, 1'b1);
            end else if (stored_edges >= MAX_EDGES) begin
               push_result(tks_pkg::STATUS_FULL, '0, 1'b1);
            end else begin
               edge_src[stored_edges] = req_src_vertex;
               edge_dst[stored_edges] = req_dst_vertex;
               stored_edges++;
               push_result(tks_pkg::STATUS_ACCEPT, '0, 1'b1);
            end
         end
         // the new count takes effect after this edge
         if (csr_wr_en) vertex_count = csr_wr_data;
      end
      pending_count = pending_results.size();
   end

endmodule

FILE: tb/sv/kahn_topological_sort_tb.sv
`timescale 1ns / 1ps
module kahn_topological_sort_tb;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_opcode;
   logic [tks_pkg::VERTEX_W-1:0] req_src_vertex;
   logic [tks_pkg::VERTEX_W-1:0] req_dst_vertex;
   logic                         rsp_valid;
   logic [tks_pkg::STATUS_W-1:0] rsp_status;
   logic [tks_pkg::VERTEX_W-1:0] rsp_vertex;
   logic                         rsp_last;
   logic                         csr_wr_en;
   logic [tks_pkg::CFG_W-1:0]    csr_wr_data;
   int                           failures;
   int                           outstanding;

   bit                           steady = 1'b0;
   int                           graph_size = 32;

   kahn_topological_sort uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_src_vertex (req_src_vertex),
      .req_dst_vertex (req_dst_vertex),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_vertex     (rsp_vertex),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   kahn_topological_sort_checker order_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_src_vertex (req_src_vertex),
      .req_dst_vertex (req_dst_vertex),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_vertex     (rsp_vertex),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .failures       (failures),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("%0t: run timed out", $time);
      $display("RESULT: ERROR");
      $finish;
   end

   // hold the transaction until the block takes it, then maybe idle a little
   task automatic issue(tks_pkg::opcode_type op, logic [tks_pkg::VERTEX_W-1:0] src,
                        logic [tks_pkg::VERTEX_W-1:0] dst);
      req_opcode <= op;
      req_src_vertex <= src;
      req_dst_vertex <= dst;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (!steady && $urandom_range(99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // drain all results and let any silent sort finish before the write
   task automatic write_vertex_count(logic [tks_pkg::CFG_W-1:0] count);
      start <= 1'b0;
      repeat (4) @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      graph_size = (count > 32) ? 32 : int'(count);
   endtask

   // mostly acyclic edges; back edges only among the top eight vertices
   task automatic random_transaction();
      int                           r;
      logic [tks_pkg::VERTEX_W-1:0] s;
      logic [tks_pkg::VERTEX_W-1:0] d;
      r = $urandom_range(99);
      if (r < 18) begin
         issue(tks_pkg::OP_SORT, tks_pkg::VERTEX_W'($urandom),
               tks_pkg::VERTEX_W'($urandom));
      end else if ((r < 30 && graph_size < 32) || graph_size < 2) begin
         s = tks_pkg::VERTEX_W'($urandom);
         d = tks_pkg::VERTEX_W'($urandom);
         if (graph_size < 32) begin
            if ($urandom_range(1)) s = tks_pkg::VERTEX_W'($urandom_range(31, graph_size));
            else d = tks_pkg::VERTEX_W'($urandom_range(31, graph_size));
         end
         issue(tks_pkg::OP_ADD, s, d);
      end else if (r < 38 && graph_size > 25) begin
         issue(tks_pkg::OP_ADD, tks_pkg::VERTEX_W'($urandom_range(graph_size - 1, 24)),
               tks_pkg::VERTEX_W'($urandom_range(graph_size - 1, 24)));
      end else begin
         s = tks_pkg::VERTEX_W'($urandom_range(graph_size - 2));
         d = tks_pkg::VERTEX_W'($urandom_range(graph_size - 1, int'(s) + 1));
         issue(tks_pkg::OP_ADD, s, d);
      end
   endtask

   initial begin
      logic [tks_pkg::CFG_W-1:0] phase_sizes [7];
      int                        guard;
      phase_sizes = '{6'd24, 6'd9, 6'd32, 6'd2, 6'd17, 6'd63, 6'd12};
      reset = 1'b1;
      start = 1'b0;
      req_opcode = tks_pkg::OP_ADD;
      req_src_vertex = '0;
      req_dst_vertex = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty graph, extremes, duplicates, a cycle, range and count corners
      write_vertex_count(6'd32);
      issue(tks_pkg::OP_SORT, 5'd0, 5'd0);
      issue(tks_pkg::OP_ADD, 5'd0, 5'd31);
      issue(tks_pkg::OP_ADD, 5'd3, 5'd4);
      issue(tks_pkg::OP_ADD, 5'd3, 5'd4);
      issue(tks_pkg::OP_ADD, 5'd31, 5'd30);
      issue(tks_pkg::OP_ADD, 5'd30, 5'd31);
      issue(tks_pkg::OP_SORT, 5'd31, 5'd31);
      // lowering the count hides the cycle and the edge to vertex 31
      write_vertex_count(6'd31);
      issue(tks_pkg::OP_ADD, 5'd31, 5'd0);
      issue(tks_pkg::OP_ADD, 5'd0, 5'd31);
      issue(tks_pkg::OP_ADD, 5'd30, 5'd29);
      issue(tks_pkg::OP_SORT, 5'd0, 5'd0);
      write_vertex_count(6'd0);
      issue(tks_pkg::OP_ADD, 5'd0, 5'd0);
      issue(tks_pkg::OP_SORT, 5'd0, 5'd0);
      write_vertex_count(6'd63);
      issue(tks_pkg::OP_ADD, 5'd31, 5'd31);
      issue(tks_pkg::OP_SORT, 5'd0, 5'd0);
      write_vertex_count(6'd1);
      issue(tks_pkg::OP_ADD, 5'd1, 5'd0);
      issue(tks_pkg::OP_ADD, 5'd0, 5'd1);
      issue(tks_pkg::OP_SORT, 5'd0, 5'd0);

      foreach (phase_sizes[p]) begin
         write_vertex_count(phase_sizes[p]);
         steady = (p == 2);
         repeat (10) random_transaction();
      end
      steady = 1'b0;

      write_vertex_count(6'd20);
      issue(tks_pkg::OP_ADD, 5'd25, 5'd3);
      issue(tks_pkg::OP_ADD, 5'd2, 5'd7);
      issue(tks_pkg::OP_SORT, 5'd0, 5'd0);
      write_vertex_count(6'd24);
      issue(tks_pkg::OP_SORT, 5'd0, 5'd0);

      start <= 1'b0;
      repeat (4) @(posedge clock);
      guard = 0;
      while ((outstanding != 0 || busy) && guard < 40000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (outstanding != 0) $display("%0t: %0d expected results never arrived", $time, outstanding);
      if (failures == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: kahn_topological_sort.f
sv/tks_pkg.sv
sv/tks_ram.sv
sv/kahn_topological_sort.sv
tb/sv/kahn_topological_sort_checker.sv
tb/sv/kahn_topological_sort_tb.sv
